// ----- hw/rtl/prewitt_pkg.sv -----
`timescale 1ns / 1ps

package prewitt_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_DIRECTION_MODE = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd2;

  // Direction mode codes; any other code gives a zero result.
  localparam logic [1:0] MODE_HORIZONTAL = 2'd0;
  localparam logic [1:0] MODE_VERTICAL   = 2'd1;

  localparam int CFG_DATA_W = 11;

  // Result queue geometry.
  localparam int QUEUE_DEPTH = 16;
  localparam int QUEUE_AW    = 4;
  // One item in flight may still add four results, the next accepted one four more.
  localparam int QUEUE_ACCEPT_LIMIT = QUEUE_DEPTH - 8;

  typedef logic [7:0] pix_t;

  // 3x3 window, entry (row * 3 + column), rows and columns oldest first.
  typedef logic [8:0][7:0] win_t;

  typedef struct packed {
    logic [7:0] pix;
    logic [9:0] col;
    logic [9:0] row;
    logic       last;
  } result_t;

  function automatic pix_t win_at(win_t w, logic [1:0] wr, logic [1:0] wc);
    logic [3:0] idx;
    idx = 4'(wr) * 4'd3 + 4'(wc);
    return w[idx];
  endfunction

  // Prewitt correlation over the rows t, m, b and columns l, c, r of the window,
  // clamped to 0..255.
  function automatic pix_t prewitt_calc(logic [1:0] mode, win_t w,
                                        logic [1:0] t, logic [1:0] m, logic [1:0] b,
                                        logic [1:0] l, logic [1:0] c, logic [1:0] r);
    logic [9:0]  pos;
    logic [9:0]  neg;
    logic [10:0] diff;
    pix_t        res;
    pos = '0;
    neg = '0;
    unique case (mode)
      MODE_HORIZONTAL: begin
        pos = 10'(win_at(w, t, l)) + 10'(win_at(w, m, l)) + 10'(win_at(w, b, l));
        neg = 10'(win_at(w, t, r)) + 10'(win_at(w, m, r)) + 10'(win_at(w, b, r));
      end
      MODE_VERTICAL: begin
        pos = 10'(win_at(w, t, l)) + 10'(win_at(w, t, c)) + 10'(win_at(w, t, r));
        neg = 10'(win_at(w, b, l)) + 10'(win_at(w, b, c)) + 10'(win_at(w, b, r));
      end
      default: begin
        pos = '0;
        neg = '0;
      end
    endcase
    diff = 11'(pos) - 11'(neg);
    if (pos <= neg) begin
      res = 8'd0;
    end else if (diff > 11'd255) begin
      res = 8'd255;
    end else begin
      res = diff[7:0];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/prewitt_edge_filter_3x3_unit.sv -----
`timescale 1ns / 1ps

// 3x3 Prewitt edge filter for a raster-order stream of 8-bit pixels with
// replicated borders. One pixel beat is accepted per clock while in_ready is
// high: the pixel's column reads both line stores out of a single dual-row
// line memory at the accept edge, and in the next cycle the window shifts, the
// line memory entry is written back (upper <- lower, lower <- pixel) and its
// zero to four finished results enter a 16-entry output queue. A pixel's
// results are computed from the stage-one registers and written into the
// queue, from which the sink takes them. Input ready drops only while the
// queue holds more than eight results, which happens when the last row emits
// two results per pixel or when the sink stalls. Writing the width or height
// restarts the frame at the top-left pixel; mode changes apply to the next
// result. Configuration is expected only while the block is idle. The line
// memory needs no clearing pass, since an entry is only used after the
// current frame has written it.
module prewitt_edge_filter_3x3_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Pixel input channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_pixel_in,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_pixel_out,
  output logic [9:0]                        out_column,
  output logic [9:0]                        out_row,
  output logic                              out_frame_last,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [prewitt_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // Configuration registers.
  logic [1:0]  mode_r;
  logic [10:0] width_r;
  logic [10:0] height_r;

  // Effective frame size after clamping to 2..MAX.
  logic [31:0] w_full;
  logic [31:0] h_full;
  logic [CW:0] w_eff;
  logic [RW:0] h_eff;

  always_comb begin
    if (width_r < 11'd2) begin
      w_full = 32'd2;
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_full = 32'(MAX_WIDTH);
    end else begin
      w_full = 32'(width_r);
    end
    if (height_r < 11'd2) begin
      h_full = 32'd2;
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_full = 32'(MAX_HEIGHT);
    end else begin
      h_full = 32'(height_r);
    end
    w_eff = w_full[CW:0];
    h_eff = h_full[RW:0];
  end

  // Position of the next pixel.
  logic [CW-1:0] cc_r;
  logic [RW-1:0] rc_r;
  logic          at_last_col;
  logic          at_last_row;
  logic          in_accept;

  assign at_last_col = ((CW + 1)'(cc_r) == w_eff - (CW + 1)'(1));
  assign at_last_row = ((RW + 1)'(rc_r) == h_eff - (RW + 1)'(1));
  assign in_accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= prewitt_pkg::MODE_HORIZONTAL;
      width_r  <= 11'd256;
      height_r <= 11'd256;
      cc_r     <= '0;
      rc_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prewitt_pkg::REG_DIRECTION_MODE: begin
          mode_r <= cfg_data[1:0];
        end
        prewitt_pkg::REG_IMAGE_WIDTH: begin
          width_r <= cfg_data;
          cc_r    <= '0;
          rc_r    <= '0;
        end
        prewitt_pkg::REG_IMAGE_HEIGHT: begin
          height_r <= cfg_data;
          cc_r     <= '0;
          rc_r     <= '0;
        end
        default: begin
          // Unknown index: the write is ignored.
        end
      endcase
    end else if (in_accept) begin
      if (at_last_col) begin
        cc_r <= '0;
        rc_r <= at_last_row ? '0 : rc_r + RW'(1);
      end else begin
        cc_r <= cc_r + CW'(1);
      end
    end
  end

  // Line memory: each entry holds {row two above, row just above} for a column.
  // It is read at the accept edge and written back in the following cycle; the next
  // accepted pixel always addresses another column, so no forwarding is needed.
  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] line_rd_r;

  // Stage one: the accepted pixel with its position flags.
  logic          s1_vld_r;
  logic [7:0]    s1_px_r;
  logic [CW-1:0] s1_cc_r;
  logic [RW-1:0] s1_rc_r;
  logic          s1_lastc_r;
  logic          s1_lastr_r;
  logic          s1_emit_r;
  logic          s1_top_r;
  logic          s1_left_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      line_rd_r <= line_mem[cc_r];
    end
    if (s1_vld_r) begin
      line_mem[s1_cc_r] <= {line_rd_r[7:0], s1_px_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px_r    <= in_pixel_in;
      s1_cc_r    <= cc_r;
      s1_rc_r    <= rc_r;
      s1_lastc_r <= at_last_col;
      s1_lastr_r <= at_last_row;
      s1_emit_r  <= (rc_r != '0) && (cc_r != '0);
      s1_top_r   <= (rc_r == RW'(1));
      s1_left_r  <= (cc_r == CW'(1));
    end
  end

  // Window shift: each row moves one column left and takes the new column.
  prewitt_pkg::win_t win_r;
  prewitt_pkg::win_t win_nxt;

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = line_rd_r[15:8];
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = line_rd_r[7:0];
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_vld_r) begin
      win_r <= win_nxt;
    end
  end

  // The four possible results of one pixel. Border replication is done by
  // picking which window rows and columns stand for top/left.
  logic [1:0] top_sel;
  logic [1:0] left_sel;
  logic [31:0] cc32;
  logic [31:0] rc32;
  logic [9:0]  col_cur;
  logic [9:0]  col_prev;
  logic [9:0]  row_cur;
  logic [9:0]  row_prev;
  prewitt_pkg::result_t res0;
  prewitt_pkg::result_t res1;
  prewitt_pkg::result_t res2;
  prewitt_pkg::result_t res3;

  assign top_sel  = s1_top_r ? 2'd1 : 2'd0;
  assign left_sel = s1_left_r ? 2'd1 : 2'd0;
  assign cc32     = 32'(s1_cc_r);
  assign rc32     = 32'(s1_rc_r);
  assign col_cur  = cc32[9:0];
  assign col_prev = 10'(cc32 - 32'd1);
  assign row_cur  = rc32[9:0];
  assign row_prev = 10'(rc32 - 32'd1);

  always_comb begin
    res0.pix  = prewitt_pkg::prewitt_calc(mode_r, win_nxt, top_sel, 2'd1, 2'd2,
                                          left_sel, 2'd1, 2'd2);
    res0.col  = col_prev;
    res0.row  = row_prev;
    res0.last = 1'b0;
    res1.pix  = prewitt_pkg::prewitt_calc(mode_r, win_nxt, top_sel, 2'd1, 2'd2,
                                          2'd1, 2'd2, 2'd2);
    res1.col  = col_cur;
    res1.row  = row_prev;
    res1.last = 1'b0;
    res2.pix  = prewitt_pkg::prewitt_calc(mode_r, win_nxt, 2'd1, 2'd2, 2'd2,
                                          left_sel, 2'd1, 2'd2);
    res2.col  = col_prev;
    res2.row  = row_cur;
    res2.last = 1'b0;
    res3.pix  = prewitt_pkg::prewitt_calc(mode_r, win_nxt, 2'd1, 2'd2, 2'd2,
                                          2'd1, 2'd2, 2'd2);
    res3.col  = col_cur;
    res3.row  = row_cur;
    res3.last = 1'b1;
  end

  // Output queue. Results of one pixel are written in row, then column order.
  localparam int QAW = prewitt_pkg::QUEUE_AW;

  prewitt_pkg::result_t queue_r [prewitt_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;
  logic [QAW:0]   count_nxt;
  logic [2:0]     n_add;
  logic           do_push;
  logic           do_pop;

  assign do_push = s1_vld_r && s1_emit_r;
  assign do_pop  = out_valid && out_ready;
  assign n_add   = do_push ? (3'd1 + 3'(s1_lastc_r) + 3'(s1_lastr_r)
                              + 3'(s1_lastc_r && s1_lastr_r)) : 3'd0;
  assign count_nxt = count_r + (QAW + 1)'(n_add) - (QAW + 1)'(do_pop);

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue_r[wr_ptr_r] <= res0;
      if (s1_lastc_r) begin
        queue_r[QAW'(wr_ptr_r + QAW'(1))] <= res1;
      end
      if (s1_lastr_r) begin
        queue_r[QAW'(wr_ptr_r + (s1_lastc_r ? QAW'(2) : QAW'(1)))] <= res2;
      end
      if (s1_lastc_r && s1_lastr_r) begin
        queue_r[QAW'(wr_ptr_r + QAW'(3))] <= res3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QAW'(n_add);
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign in_ready       = (32'(count_r) <= prewitt_pkg::QUEUE_ACCEPT_LIMIT);
  assign out_valid      = (count_r != '0);
  assign out_pixel_out  = queue_r[rd_ptr_r].pix;
  assign out_column     = queue_r[rd_ptr_r].col;
  assign out_row        = queue_r[rd_ptr_r].row;
  assign out_frame_last = queue_r[rd_ptr_r].last;

  // Checks.
  logic [31:0] w_last32;
  logic [31:0] h_last32;
  assign w_last32 = 32'(w_eff) - 32'd1;
  assign h_last32 = 32'(h_eff) - 32'd1;

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) + 32'(n_add) <= prewitt_pkg::QUEUE_DEPTH)
    else $error("result queue overflow");

  a_line_mem_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && in_accept) |-> (cc_r != s1_cc_r))
    else $error("line memory read and write-back hit the same column");

  a_frame_last_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_last) |->
      (out_column == w_last32[9:0] && out_row == h_last32[9:0]))
    else $error("frame_last on a result that is not the bottom-right pixel");

  a_pop_only_when_filled: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (count_r == $past(count_r) + (QAW + 1)'($past(n_add))
                - (QAW + 1)'(1)))
    else $error("queue count out of step with push and pop");

endmodule
